// ===== sv/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg
// Types, register codes and CORDIC constants for the sky coordinate rotation.
// ----------------------------------------------------------------------------
`default_nettype none

package scr_pkg;

	typedef struct packed {
		logic        [31:0] ra_in;
		logic signed [31:0] dec_in;
	} point_t;

	typedef struct packed {
		logic        [31:0] ra_out;
		logic signed [31:0] dec_out;
	} result_t;

	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ANGLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE      = 1'd1;

	localparam int VEC_W    = 64;
	localparam int VEC_FRAC = 56;

	// 1/G of the infinite CORDIC chain, Q62
	localparam logic [63:0] INV_GAIN       = 64'd2800459870029452966;
	localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;

	// atan(2^-i) in turns, Q62, from the arctangent series
	function automatic logic [63:0] atan_q62(input int i);
		logic [63:0]  rad;
		logic [63:0]  term;
		logic [127:0] prod;
		int           e;
		if (i == 0) begin
			return 64'd1 << 59;
		end
		rad = '0;
		for (int k = 0; k < 64; k++) begin
			e = 62 - i * (2 * k + 1);
			if (e >= 0) begin
				term = (64'd1 << e) / 64'(2 * k + 1);
				if ((k % 2) == 1) begin
					rad = rad - term;
				end else begin
					rad = rad + term;
				end
			end
		end
		prod = 128'(rad) * 128'(INV_TWO_PI_Q64);
		return prod[127:64];
	endfunction

	// table entry rounded to nearest at the given phase resolution
	function automatic logic [63:0] atan_phase(input int i, input int angle_bits);
		logic [63:0] t;
		t = atan_q62(i);
		return (t + (64'd1 << (61 - angle_bits))) >> (62 - angle_bits);
	endfunction

endpackage

`default_nettype wire

// ===== sv/scr_cordic_rot.sv =====
// ----------------------------------------------------------------------------
// scr_cordic_rot
// Rotation-mode CORDIC, one register stage per micro-rotation, with the
// half-turn fold in front.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_cordic_rot #(
	parameter int ANGLE_BITS    = 32,
	parameter int CORDIC_STAGES = 28,
	parameter int SIDE_W        = 1
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         en,
	input  wire                         in_v,
	input  wire  signed [63:0]          in_x,
	input  wire  signed [63:0]          in_y,
	input  wire         [ANGLE_BITS-1:0] in_ph,
	input  wire         [SIDE_W-1:0]    in_side,
	output logic                        out_v,
	output logic signed [63:0]          out_x,
	output logic signed [63:0]          out_y,
	output logic        [SIDE_W-1:0]    out_side
);

	localparam int ZW = ANGLE_BITS + 2;
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

	logic                     v_s    [CORDIC_STAGES+1];
	logic signed [63:0]       x_s    [CORDIC_STAGES+1];
	logic signed [63:0]       y_s    [CORDIC_STAGES+1];
	logic signed [ZW-1:0]     z_s    [CORDIC_STAGES+1];
	logic        [SIDE_W-1:0] side_s [CORDIC_STAGES+1];

	logic [ANGLE_BITS-1:0] wrap;
	logic                  flip;
	logic [ANGLE_BITS-1:0] ph_adj;

	assign wrap   = in_ph + QUARTER;
	assign flip   = wrap[ANGLE_BITS-1];
	assign ph_adj = flip ? (in_ph ^ HALF) : in_ph;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= flip ? -in_x : in_x;
			y_s[0]    <= flip ? -in_y : in_y;
			z_s[0]    <= ZW'($signed(ph_adj));
			side_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic signed [ZW-1:0] ATAN = ZW'(scr_pkg::atan_phase(i, ANGLE_BITS));

		logic signed [63:0] dx;
		logic signed [63:0] dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ATAN;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ATAN;
				end
			end
		end
	end

	assign out_v    = v_s[CORDIC_STAGES];
	assign out_x    = x_s[CORDIC_STAGES];
	assign out_y    = y_s[CORDIC_STAGES];
	assign out_side = side_s[CORDIC_STAGES];

endmodule

`default_nettype wire

// ===== sv/scr_cordic_vec.sv =====
// ----------------------------------------------------------------------------
// scr_cordic_vec
// Vectoring-mode CORDIC (atan2 and magnitude), one register stage per
// micro-rotation, with the left half-plane fold and zero-vector flag.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_cordic_vec #(
	parameter int ANGLE_BITS    = 32,
	parameter int CORDIC_STAGES = 28,
	parameter int SIDE_W        = 1
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          in_v,
	input  wire  signed [63:0]           in_x,
	input  wire  signed [63:0]           in_y,
	input  wire         [SIDE_W-1:0]     in_side,
	output logic                         out_v,
	output logic signed [ANGLE_BITS+1:0] out_ang,
	output logic signed [63:0]           out_mag,
	output logic        [SIDE_W-1:0]     out_side
);

	localparam int ZW = ANGLE_BITS + 2;
	localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (ANGLE_BITS - 1);

	logic                     v_s    [CORDIC_STAGES+1];
	logic                     zero_s [CORDIC_STAGES+1];
	logic signed [63:0]       x_s    [CORDIC_STAGES+1];
	logic signed [63:0]       y_s    [CORDIC_STAGES+1];
	logic signed [ZW-1:0]     z_s    [CORDIC_STAGES+1];
	logic        [SIDE_W-1:0] side_s [CORDIC_STAGES+1];

	logic neg;

	assign neg = in_x[63];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (in_x == '0) && (in_y == '0);
			x_s[0]    <= neg ? -in_x : in_x;
			y_s[0]    <= neg ? -in_y : in_y;
			z_s[0]    <= neg ? HALF : '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic signed [ZW-1:0] ATAN = ZW'(scr_pkg::atan_phase(i, ANGLE_BITS));

		logic signed [63:0] dx;
		logic signed [63:0] dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 64'sd0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ATAN;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ATAN;
				end
			end
		end
	end

	assign out_v    = v_s[CORDIC_STAGES];
	assign out_ang  = zero_s[CORDIC_STAGES] ? '0 : z_s[CORDIC_STAGES];
	assign out_mag  = zero_s[CORDIC_STAGES] ? '0 : x_s[CORDIC_STAGES];
	assign out_side = side_s[CORDIC_STAGES];

endmodule

`default_nettype wire

// ===== sv/scr_gain.sv =====
// ----------------------------------------------------------------------------
// scr_gain
// CORDIC gain correction: sign-magnitude multiply by 1/G in Q62, built from
// 32x32 partial products over five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_gain #(
	parameter int LANES  = 1,
	parameter int SIDE_W = 1
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire                      in_v,
	input  wire  [LANES-1:0][63:0]   in_val,
	input  wire  [SIDE_W-1:0]        in_side,
	output logic                     out_v,
	output logic [LANES-1:0][63:0]   out_val,
	output logic [SIDE_W-1:0]        out_side
);

	localparam logic [31:0] G0 = scr_pkg::INV_GAIN[31:0];
	localparam logic [31:0] G1 = scr_pkg::INV_GAIN[63:32];

	logic                    v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [SIDE_W-1:0]       side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [LANES-1:0]        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [LANES-1:0][63:0]  mag_s1;
	logic [LANES-1:0][63:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic [LANES-1:0][63:0]  p00_s3, p11_s3;
	logic [LANES-1:0][64:0]  mid_s3;
	logic [LANES-1:0][63:0]  r_s4;
	logic [LANES-1:0][63:0]  r_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			neg_s2  <= neg_s1;
			neg_s3  <= neg_s2;
			neg_s4  <= neg_s3;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [127:0] prod;

		assign prod = {p11_s3[l], p00_s3[l]} + {31'd0, mid_s3[l], 32'd0};

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s1[l] <= in_val[l][63];
				mag_s1[l] <= in_val[l][63] ? -in_val[l] : in_val[l];

				p00_s2[l] <= 64'(mag_s1[l][31:0])  * 64'(G0);
				p01_s2[l] <= 64'(mag_s1[l][31:0])  * 64'(G1);
				p10_s2[l] <= 64'(mag_s1[l][63:32]) * 64'(G0);
				p11_s2[l] <= 64'(mag_s1[l][63:32]) * 64'(G1);

				p00_s3[l] <= p00_s2[l];
				p11_s3[l] <= p11_s2[l];
				mid_s3[l] <= 65'(p01_s2[l]) + 65'(p10_s2[l]);

				r_s4[l] <= prod[125:62];

				r_s5[l] <= neg_s4[l] ? -r_s4[l] : r_s4[l];
			end
		end
	end

	assign out_v    = v_s5;
	assign out_val  = r_s5;
	assign out_side = side_s5;

endmodule

`default_nettype wire

// ===== sv/sky_coordinate_rotation.sv =====
// ----------------------------------------------------------------------------
// sky_coordinate_rotation
// Converts a sky point to a unit vector, rotates it by the configured angle
// in the x-z or x-y plane and converts back to right ascension/declination.
//
//   channel  direction  handshake              payload
//   point    in         point_valid/point_stall  scr_pkg::point_t
//   result   out        result_valid/result_stall scr_pkg::result_t
//   cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item per cycle while not held. The pipeline is built from five
// CORDIC chains, three gain multipliers of five stages each, output register.
// The whole pipeline advances together; it holds only while a result is
// waiting under result_stall, and point_stall follows that.
// Reset clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sky_coordinate_rotation #(
	parameter int ANGLE_BITS    = 32,
	parameter int CORDIC_STAGES = 28
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                point_valid,
	output logic                               point_stall,
	input  wire  scr_pkg::point_t              point,
	output logic                               result_valid,
	input  wire                                result_stall,
	output scr_pkg::result_t                   result,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [scr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [31:0]                        cfg_data
);

	localparam int ZW = ANGLE_BITS + 2;
	localparam logic signed [63:0] UNIT = 64'sd1 <<< scr_pkg::VEC_FRAC;
	localparam logic signed [33:0] DEC_MAX = 34'sd1 <<< 30;

	logic [31:0] rotation_angle_q;
	logic        axis_mode_q;
	logic        en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_angle_q <= '0;
			axis_mode_q      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				scr_pkg::REG_ROTATION_ANGLE: rotation_angle_q <= cfg_data;
				scr_pkg::REG_AXIS_MODE:      axis_mode_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en          = !(result_valid && result_stall);
	assign point_stall = !en;

	// phase scaling
	logic [ANGLE_BITS-1:0] ra_ph, dec_ph, ang_ph;

	if (ANGLE_BITS >= 32) begin : g_up
		assign ra_ph  = ANGLE_BITS'(point.ra_in) << (ANGLE_BITS - 32);
		assign dec_ph = ANGLE_BITS'(point.dec_in) << (ANGLE_BITS - 32);
		assign ang_ph = ANGLE_BITS'(rotation_angle_q) << (ANGLE_BITS - 32);
	end else begin : g_dn
		assign ra_ph  = ANGLE_BITS'(point.ra_in >> (32 - ANGLE_BITS));
		assign dec_ph = ANGLE_BITS'(point.dec_in >> (32 - ANGLE_BITS));
		assign ang_ph = ANGLE_BITS'(rotation_angle_q >> (32 - ANGLE_BITS));
	end

	// declination rotation of (1, 0)
	logic                  r1_v;
	logic signed [63:0]    r1_x, r1_y;
	logic [ANGLE_BITS-1:0] r1_ra;

	scr_cordic_rot #(
		.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(ANGLE_BITS)
	) u_rot_dec (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(point_valid), .in_x(UNIT), .in_y(64'sd0), .in_ph(dec_ph), .in_side(ra_ph),
		.out_v(r1_v), .out_x(r1_x), .out_y(r1_y), .out_side(r1_ra)
	);

	// right ascension rotation of (r, 0)
	logic               r2_v;
	logic signed [63:0] r2_x, r2_y;
	logic [63:0]        r2_z;

	scr_cordic_rot #(
		.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(64)
	) u_rot_ra (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(r1_v), .in_x(r1_x), .in_y(64'sd0), .in_ph(r1_ra), .in_side(r1_y),
		.out_v(r2_v), .out_x(r2_x), .out_y(r2_y), .out_side(r2_z)
	);

	logic             g1_v;
	logic [1:0][63:0] g1_val;
	logic [63:0]      g1_z;

	scr_gain #(.LANES(2), .SIDE_W(64)) u_gain_xy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(r2_v), .in_val({r2_y, r2_x}), .in_side(r2_z),
		.out_v(g1_v), .out_val(g1_val), .out_side(g1_z)
	);

	// configured rotation: pair (x, y) or (x, z), the third component rides along
	logic [63:0] pair_b, other;

	assign pair_b = axis_mode_q ? g1_val[1] : g1_z;
	assign other  = axis_mode_q ? g1_z : g1_val[1];

	logic               r3_v;
	logic signed [63:0] r3_a, r3_b;
	logic [64:0]        r3_side;

	scr_cordic_rot #(
		.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(65)
	) u_rot_cfg (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(g1_v), .in_x(g1_val[0]), .in_y(pair_b), .in_ph(ang_ph),
		.in_side({axis_mode_q, other}),
		.out_v(r3_v), .out_x(r3_a), .out_y(r3_b), .out_side(r3_side)
	);

	logic             g2_v;
	logic [1:0][63:0] g2_val;
	logic [64:0]      g2_side;

	scr_gain #(.LANES(2), .SIDE_W(65)) u_gain_cfg (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(r3_v), .in_val({r3_b, r3_a}), .in_side(r3_side),
		.out_v(g2_v), .out_val(g2_val), .out_side(g2_side)
	);

	logic [63:0] x4, y4, z4;

	assign x4 = g2_val[0];
	assign y4 = g2_side[64] ? g2_val[1] : g2_side[63:0];
	assign z4 = g2_side[64] ? g2_side[63:0] : g2_val[1];

	// right ascension and equatorial magnitude
	logic                 v1_v;
	logic signed [ZW-1:0] v1_ang;
	logic signed [63:0]   v1_mag;
	logic [63:0]          v1_z;

	scr_cordic_vec #(
		.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(64)
	) u_vec_ra (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(g2_v), .in_x(x4), .in_y(y4), .in_side(z4),
		.out_v(v1_v), .out_ang(v1_ang), .out_mag(v1_mag), .out_side(v1_z)
	);

	logic          g3_v;
	logic [0:0][63:0] g3_val;
	logic [ZW+63:0] g3_side;

	scr_gain #(.LANES(1), .SIDE_W(ZW + 64)) u_gain_mag (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(v1_v), .in_val(v1_mag), .in_side({v1_ang, v1_z}),
		.out_v(g3_v), .out_val(g3_val), .out_side(g3_side)
	);

	// declination
	logic                 v2_v;
	logic signed [ZW-1:0] v2_ang;
	logic [ZW-1:0]        v2_ra;

	scr_cordic_vec #(
		.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(ZW)
	) u_vec_dec (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(g3_v), .in_x(g3_val[0]), .in_y(g3_side[63:0]), .in_side(g3_side[ZW+63:64]),
		.out_v(v2_v), .out_ang(v2_ang), .out_mag(), .out_side(v2_ra)
	);

	// back to 32-bit angles, declination clamped to a quarter turn
	logic [ANGLE_BITS-1:0] ra_fold;
	logic [31:0]           ra_w;
	logic signed [33:0]    dec_w;
	logic signed [33:0]    dec_c;

	assign ra_fold = v2_ra[ANGLE_BITS-1:0];

	if (ANGLE_BITS >= 32) begin : g_out_dn
		assign ra_w  = 32'(ra_fold >> (ANGLE_BITS - 32));
		assign dec_w = 34'(v2_ang >>> (ANGLE_BITS - 32));
	end else begin : g_out_up
		assign ra_w  = 32'(ra_fold) << (32 - ANGLE_BITS);
		assign dec_w = 34'(v2_ang) <<< (32 - ANGLE_BITS);
	end

	always_comb begin
		dec_c = dec_w;
		if (dec_w > DEC_MAX) begin
			dec_c = DEC_MAX;
		end else if (dec_w < -DEC_MAX) begin
			dec_c = -DEC_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= v2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.ra_out  <= ra_w;
			result.dec_out <= dec_c[31:0];
		end
	end

endmodule

`default_nettype wire
